@@ rtl/mp3bc_pkg.sv @@
// Package for the MP3 module button controller: event codes, frame bytes,
// and the result job handed from the controller to the frame serializer.
// No dependencies.
`default_nettype none
package mp3bc_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_KEY   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [2:0] KEY_UP    = 3'd0;
    localparam logic [2:0] KEY_DOWN  = 3'd1;
    localparam logic [2:0] KEY_RIGHT = 3'd2;
    localparam logic [2:0] KEY_LEFT  = 3'd3;
    localparam logic [2:0] KEY_OK    = 3'd4;
    localparam logic [2:0] KEY_BACK  = 3'd5;

    localparam logic [2:0] KIND_SHORT = 3'd2;
    localparam logic [2:0] KIND_LONG  = 3'd3;

    localparam logic [1:0] SCR_SPLASH = 2'd0;
    localparam logic [1:0] SCR_PLAYER = 2'd1;
    localparam logic [1:0] SCR_HELP   = 2'd2;

    localparam logic [7:0] FRM_START = 8'h7E;
    localparam logic [7:0] FRM_VER   = 8'hFF;
    localparam logic [7:0] FRM_LEN   = 8'h06;
    localparam logic [7:0] FRM_END   = 8'hEF;
    localparam logic [7:0] FRM_ZERO  = 8'h00;

    localparam logic [7:0] OP_PLAY_FIRST = 8'h0F;
    localparam logic [7:0] OP_PAUSE      = 8'h0E;
    localparam logic [7:0] OP_RESUME     = 8'h0D;
    localparam logic [7:0] OP_NEXT       = 8'h01;
    localparam logic [7:0] OP_PREV       = 8'h02;
    localparam logic [7:0] OP_SET_VOL    = 8'h06;
    localparam logic [7:0] PLAY_FIRST_ARG = 8'h01;

    localparam logic [4:0] VOL_MAX     = 5'd30;
    localparam logic [7:0] SPLASH_SAT  = 8'd255;

    // number of frames an item emits
    localparam logic [1:0] NFR_NONE = 2'd0;
    localparam logic [1:0] NFR_ONE  = 2'd1;
    localparam logic [1:0] NFR_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0] screen;
        logic       playing;
        logic [4:0] volume;
        logic [6:0] progress;
        logic [7:0] anim;
        logic       halted;
    } t_status;

    // second frame, when present, is always play-first
    typedef struct packed {
        logic [1:0] nfr;
        logic [7:0] cmd_a;
        logic [7:0] lo_a;
        t_status    status;
    } t_job;

endpackage
`default_nettype wire

@@ rtl/mp3_module_button_controller_unit.sv @@
// MP3 module button controller top level: input register, player state,
// configuration registers and event decode. Depends on mp3bc_pkg, mp3bc_framer.
// Path: input register, serializer job register. Throughput: an item yields
// 1, 8 or 16 results, one per cycle while the receiver is ready; the next
// item waits in the input register and moves on as the serializer hands out
// its last result, so the serializer sets the rate. Synchronous active-low
// reset restores player state and configuration defaults.
`default_nettype none
module mp3_module_button_controller_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data,
    // input items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // key[2:0], press_kind[5:3], zero[7:6]
    input  wire  [1:0]  s_axis_tuser,   // command[1:0]
    // results
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // frame_byte[7:0], screen[9:8], playing[10],
                                        // volume_now[15:11], progress_now[22:16],
                                        // anim_frame[30:23], halted[31]
    output logic        m_axis_tuser,   // has_byte[0]
    output logic        m_axis_tlast
);
    import mp3bc_pkg::*;

    localparam logic [1:0] REG_INIT_VOL  = 2'd0;
    localparam logic [1:0] REG_VOL_LIM   = 2'd1;
    localparam logic [1:0] REG_SPLASH    = 2'd2;
    localparam logic [1:0] REG_PROG_LIM  = 2'd3;

    logic [4:0] r_init_vol;
    logic [4:0] r_vol_lim;
    logic [7:0] r_splash_len;
    logic [6:0] r_prog_lim;

    logic       r_in_valid;
    logic [1:0] r_in_cmd;
    logic [2:0] r_in_key;
    logic [2:0] r_in_kind;

    logic [1:0] r_screen;
    logic       r_play;
    logic [4:0] r_vol;
    logic [6:0] r_prog;
    logic [7:0] r_anim;
    logic [7:0] r_splash_cnt;
    logic       r_halt;

    logic [1:0] n_screen;
    logic       n_play;
    logic [4:0] n_vol;
    logic [6:0] n_prog;
    logic [7:0] n_anim;
    logic [7:0] n_splash_cnt;
    logic       n_halt;
    logic [1:0] n_nfr;
    logic [7:0] n_cmd;
    logic [4:0] n_sent;

    logic       w_load;
    logic       w_free;
    logic [4:0] w_lim;
    logic [7:0] w_prog_inc;
    t_job       w_job;
    t_status    w_stat;
    logic       w_has_byte;
    logic [7:0] w_byte;

    assign o_cfg_ready   = 1'b1;
    assign w_load        = r_in_valid && w_free;
    assign s_axis_tready = !r_in_valid || w_free;
    assign w_lim         = (r_vol_lim > VOL_MAX) ? VOL_MAX : r_vol_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_vol   <= 5'd20;
            r_vol_lim    <= 5'd30;
            r_splash_len <= 8'd4;
            r_prog_lim   <= 7'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_INIT_VOL: r_init_vol   <= i_cfg_data[4:0];
                REG_VOL_LIM:  r_vol_lim    <= i_cfg_data[4:0];
                REG_SPLASH:   r_splash_len <= i_cfg_data;
                REG_PROG_LIM: r_prog_lim   <= i_cfg_data[6:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_key  <= s_axis_tdata[2:0];
            r_in_kind <= s_axis_tdata[5:3];
        end
    end

    always_comb begin
        n_screen     = r_screen;
        n_play       = r_play;
        n_vol        = r_vol;
        n_prog       = r_prog;
        n_anim       = r_anim;
        n_splash_cnt = r_splash_cnt;
        n_halt       = r_halt;
        n_nfr        = NFR_NONE;
        n_cmd        = OP_PAUSE;
        w_prog_inc   = {1'b0, r_prog} + 8'd1;
        if (!r_halt) begin
            unique case (r_in_cmd)
                CMD_TICK: begin
                    if (r_screen == SCR_SPLASH) begin
                        if (r_splash_cnt != SPLASH_SAT) begin
                            n_splash_cnt = r_splash_cnt + 8'd1;
                        end
                        if (n_splash_cnt >= r_splash_len) begin
                            n_screen = SCR_PLAYER;
                        end
                    end
                    if (r_play && n_screen == SCR_PLAYER) begin
                        n_anim = r_anim + 8'd1;
                        n_prog = (w_prog_inc > {1'b0, r_prog_lim}) ? 7'd0 : w_prog_inc[6:0];
                    end
                end
                CMD_START: begin
                    n_vol  = (r_init_vol > w_lim) ? w_lim : r_init_vol;
                    n_play = 1'b1;
                    n_nfr  = NFR_TWO;
                    n_cmd  = OP_SET_VOL;
                end
                CMD_KEY: begin
                    if (r_in_kind == KIND_LONG && r_in_key == KEY_BACK) begin
                        n_halt = 1'b1;
                        n_nfr  = NFR_ONE;
                        n_cmd  = OP_PAUSE;
                    end else if (r_screen == SCR_SPLASH) begin
                        n_screen = SCR_PLAYER;
                    end else if (r_screen == SCR_HELP) begin
                        if (r_in_kind == KIND_SHORT
                                && (r_in_key == KEY_OK || r_in_key == KEY_BACK)) begin
                            n_screen = SCR_PLAYER;
                        end
                    end else if (r_screen == SCR_PLAYER) begin
                        if (r_in_kind == KIND_LONG && r_in_key == KEY_OK) begin
                            n_screen = SCR_HELP;
                        end else if (r_in_kind == KIND_SHORT) begin
                            n_nfr = NFR_ONE;
                            unique case (r_in_key)
                                KEY_OK: begin
                                    n_cmd  = r_play ? OP_PAUSE : OP_RESUME;
                                    n_play = !r_play;
                                end
                                KEY_RIGHT: begin
                                    n_prog = 7'd0;
                                    n_play = 1'b1;
                                    n_cmd  = OP_NEXT;
                                end
                                KEY_LEFT: begin
                                    n_prog = 7'd0;
                                    n_play = 1'b1;
                                    n_cmd  = OP_PREV;
                                end
                                KEY_UP: begin
                                    if (r_vol < w_lim) begin
                                        n_vol = r_vol + 5'd1;
                                    end
                                    n_cmd = OP_SET_VOL;
                                end
                                KEY_DOWN: begin
                                    if (r_vol != 5'd0) begin
                                        n_vol = r_vol - 5'd1;
                                    end
                                    n_cmd = OP_SET_VOL;
                                end
                                KEY_BACK: begin
                                    n_play = 1'b0;
                                    n_cmd  = OP_PAUSE;
                                end
                                default: begin
                                    n_nfr = NFR_NONE;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        n_sent = (n_vol > w_lim) ? w_lim : n_vol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen     <= SCR_SPLASH;
            r_play       <= 1'b1;
            r_vol        <= 5'd20;
            r_prog       <= 7'd0;
            r_anim       <= 8'd0;
            r_splash_cnt <= 8'd0;
            r_halt       <= 1'b0;
        end else if (w_load) begin
            r_screen     <= n_screen;
            r_play       <= n_play;
            r_vol        <= n_vol;
            r_prog       <= n_prog;
            r_anim       <= n_anim;
            r_splash_cnt <= n_splash_cnt;
            r_halt       <= n_halt;
        end
    end

    always_comb begin
        w_job.nfr             = n_nfr;
        w_job.cmd_a           = n_cmd;
        w_job.lo_a            = (n_cmd == OP_SET_VOL) ? {3'd0, n_sent} : FRM_ZERO;
        w_job.status.screen   = n_screen;
        w_job.status.playing  = n_play;
        w_job.status.volume   = n_vol;
        w_job.status.progress = n_prog;
        w_job.status.anim     = n_anim;
        w_job.status.halted   = n_halt;
    end

    mp3bc_framer u_framer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_job      (w_job),
        .o_free     (w_free),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_has_byte (w_has_byte),
        .o_byte     (w_byte),
        .o_last     (m_axis_tlast),
        .o_status   (w_stat)
    );

    assign m_axis_tuser = w_has_byte;
    assign m_axis_tdata = {w_stat.halted, w_stat.anim, w_stat.progress, w_stat.volume,
                           w_stat.playing, w_stat.screen, w_byte};

endmodule
`default_nettype wire

@@ rtl/mp3bc_framer.sv @@
// Frame serializer: holds one result job and emits its results one per cycle while the receiver is ready.
// Depends on mp3bc_pkg.
`default_nettype none
module mp3bc_framer (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  mp3bc_pkg::t_job     i_job,
    output logic                o_free,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic                o_has_byte,
    output logic [7:0]          o_byte,
    output logic                o_last,
    output mp3bc_pkg::t_status  o_status
);
    import mp3bc_pkg::*;

    logic       r_busy;
    logic [3:0] r_idx;
    t_job       r_job;
    logic       w_last;
    logic       w_take;
    logic [7:0] w_cmd;
    logic [7:0] w_hi;
    logic [7:0] w_lo;

    always_comb begin
        unique case (r_job.nfr)
            NFR_NONE: w_last = (r_idx == 4'd0);
            NFR_ONE:  w_last = (r_idx == 4'd7);
            default:  w_last = (r_idx == 4'd15);
        endcase
    end

    assign w_take = r_busy && i_ready;
    assign o_free = !r_busy || (w_take && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 4'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= 4'd0;
        end else if (w_take) begin
            r_busy <= !w_last;
            r_idx  <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

    always_comb begin
        w_cmd = r_idx[3] ? OP_PLAY_FIRST  : r_job.cmd_a;
        w_hi  = r_idx[3] ? PLAY_FIRST_ARG : FRM_ZERO;
        w_lo  = r_idx[3] ? PLAY_FIRST_ARG : r_job.lo_a;
        unique case (r_idx[2:0])
            3'd0:    o_byte = FRM_START;
            3'd1:    o_byte = FRM_VER;
            3'd2:    o_byte = FRM_LEN;
            3'd3:    o_byte = w_cmd;
            3'd4:    o_byte = FRM_ZERO;
            3'd5:    o_byte = w_hi;
            3'd6:    o_byte = w_lo;
            default: o_byte = FRM_END;
        endcase
        if (r_job.nfr == NFR_NONE) begin
            o_byte = FRM_ZERO;
        end
    end

    assign o_valid    = r_busy;
    assign o_has_byte = (r_job.nfr != NFR_NONE);
    assign o_last     = w_last;
    assign o_status   = r_job.status;

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Testbench for mp3_module_button_controller_unit: drives tick, key and start items,
// predicts every command byte and status result, and checks them in order.
// Depends on mp3bc_pkg and the controller RTL.
module tb;
    import mp3bc_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [2:0] KEY_UNUSED   = 3'd6;
    localparam logic [2:0] KIND_PRESS   = 3'd0;
    localparam logic [2:0] KIND_RELEASE = 3'd1;
    localparam logic [2:0] KIND_REPEAT  = 3'd4;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 8;

    typedef enum logic [1:0] {
        REG_INIT_VOLUME    = 2'd0,
        REG_VOLUME_LIMIT   = 2'd1,
        REG_SPLASH_LENGTH  = 2'd2,
        REG_PROGRESS_LIMIT = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] frame_byte;
        logic       is_last;
        logic [1:0] screen;
        logic       playing;
        logic [4:0] volume;
        logic [6:0] progress;
        logic [7:0] anim;
        logic       halted;
    } t_ctrl_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic [1:0]  s_axis_tuser = 2'd0;
    logic        m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    mp3_module_button_controller_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predicted player state and registers
    logic [4:0] cfg_init_vol;
    logic [4:0] cfg_vol_limit;
    logic [7:0] cfg_splash_len;
    logic [6:0] cfg_prog_limit;
    logic [1:0] scr;
    logic       play_on;
    logic [4:0] vol;
    logic [6:0] prog;
    logic [7:0] anim;
    logic [7:0] splash_cnt;
    logic       halted_q;

    t_ctrl_result expected_results[$];
    logic [7:0]   frame_bytes[$];

    int error_count = 0;
    int result_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 33;
    int recv_idle_pct = 80;
    int stall_request = 0;
    int stall_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reset_predictor();
        cfg_init_vol   = 5'd20;
        cfg_vol_limit  = 5'd30;
        cfg_splash_len = 8'd4;
        cfg_prog_limit = 7'd100;
        scr        = SCR_SPLASH;
        play_on    = 1'b1;
        vol        = 5'd20;
        prog       = 7'd0;
        anim       = 8'd0;
        splash_cnt = 8'd0;
        halted_q   = 1'b0;
    endfunction

    function automatic void add_frame(input logic [7:0] op, input logic [7:0] hi,
                                      input logic [7:0] lo);
        frame_bytes.push_back(FRM_START);
        frame_bytes.push_back(FRM_VER);
        frame_bytes.push_back(FRM_LEN);
        frame_bytes.push_back(op);
        frame_bytes.push_back(FRM_ZERO);
        frame_bytes.push_back(hi);
        frame_bytes.push_back(lo);
        frame_bytes.push_back(FRM_END);
    endfunction

    function automatic t_ctrl_result make_result(input logic hb, input logic [7:0] b,
                                                 input logic lst);
        t_ctrl_result r;
        r.has_byte   = hb;
        r.frame_byte = b;
        r.is_last    = lst;
        r.screen     = scr;
        r.playing    = play_on;
        r.volume     = vol;
        r.progress   = prog;
        r.anim       = anim;
        r.halted     = halted_q;
        return r;
    endfunction

    function automatic void predict_event(input logic [1:0] cmd, input logic [2:0] key,
                                          input logic [2:0] kind);
        logic [4:0] lim;
        logic [7:0] next_prog;
        lim = (cfg_vol_limit > VOL_MAX) ? VOL_MAX : cfg_vol_limit;
        frame_bytes.delete();
        if (halted_q) begin
        end else if (cmd == CMD_TICK) begin
            if (scr == SCR_SPLASH) begin
                if (splash_cnt != SPLASH_SAT) splash_cnt = splash_cnt + 8'd1;
                if (splash_cnt >= cfg_splash_len) scr = SCR_PLAYER;
            end
            if (play_on && scr == SCR_PLAYER) begin
                anim = anim + 8'd1;
                next_prog = {1'b0, prog} + 8'd1;
                prog = (next_prog > {1'b0, cfg_prog_limit}) ? 7'd0 : next_prog[6:0];
            end
        end else if (cmd == CMD_START) begin
            vol = (cfg_init_vol > lim) ? lim : cfg_init_vol;
            play_on = 1'b1;
            add_frame(OP_SET_VOL, FRM_ZERO, {3'b000, vol});
            add_frame(OP_PLAY_FIRST, PLAY_FIRST_ARG, PLAY_FIRST_ARG);
        end else if (cmd == CMD_KEY) begin
            if (kind == KIND_LONG && key == KEY_BACK) begin
                halted_q = 1'b1;
                add_frame(OP_PAUSE, FRM_ZERO, FRM_ZERO);
            end else if (scr == SCR_SPLASH) begin
                scr = SCR_PLAYER;
            end else if (scr == SCR_HELP) begin
                if (kind == KIND_SHORT && (key == KEY_OK || key == KEY_BACK)) scr = SCR_PLAYER;
            end else if (scr == SCR_PLAYER) begin
                if (kind == KIND_LONG && key == KEY_OK) begin
                    scr = SCR_HELP;
                end else if (kind == KIND_SHORT) begin
                    case (key)
                        KEY_OK: begin
                            add_frame(play_on ? OP_PAUSE : OP_RESUME, FRM_ZERO, FRM_ZERO);
                            play_on = ~play_on;
                        end
                        KEY_RIGHT, KEY_LEFT: begin
                            prog = 7'd0;
                            play_on = 1'b1;
                            add_frame((key == KEY_RIGHT) ? OP_NEXT : OP_PREV, FRM_ZERO, FRM_ZERO);
                        end
                        KEY_UP, KEY_DOWN: begin
                            if (key == KEY_UP && vol < lim) vol = vol + 5'd1;
                            if (key == KEY_DOWN && vol != 5'd0) vol = vol - 5'd1;
                            add_frame(OP_SET_VOL, FRM_ZERO, {3'b000, (vol > lim) ? lim : vol});
                        end
                        KEY_BACK: begin
                            play_on = 1'b0;
                            add_frame(OP_PAUSE, FRM_ZERO, FRM_ZERO);
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
        if (frame_bytes.size() == 0) begin
            expected_results.push_back(make_result(1'b0, 8'd0, 1'b1));
        end else begin
            foreach (frame_bytes[k])
                expected_results.push_back(make_result(1'b1, frame_bytes[k],
                                                       k == frame_bytes.size() - 1));
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch on %s at result %0d: got %0d, want %0d",
                 what, result_count, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_ctrl_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 0);
            end else begin
                want = expected_results.pop_front();
                check_field("has_byte", m_axis_tuser, want.has_byte);
                check_field("frame_byte", m_axis_tdata[7:0], want.frame_byte);
                check_field("last", m_axis_tlast, want.is_last);
                check_field("screen", m_axis_tdata[9:8], want.screen);
                check_field("playing", m_axis_tdata[10], want.playing);
                check_field("volume_now", m_axis_tdata[15:11], want.volume);
                check_field("progress_now", m_axis_tdata[22:16], want.progress);
                check_field("anim_frame", m_axis_tdata[30:23], want.anim);
                check_field("halted", m_axis_tdata[31], want.halted);
            end
            result_count++;
        end
    end

    // receiver: random idling plus requested long holds
    always @(posedge i_clk) begin
        if (stall_request != 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic wait_idle(input int settle);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic configure(input logic [4:0] init_vol, input logic [4:0] vol_lim,
                             input logic [7:0] splash_len, input logic [6:0] prog_lim);
        logic [7:0] values [4];
        values[0] = {3'b000, init_vol};
        values[1] = {3'b000, vol_lim};
        values[2] = splash_len;
        values[3] = {1'b0, prog_lim};
        wait_idle(SETTLE);
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_reg_index'(i);
            i_cfg_data  <= values[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (t_reg_index'(i))
                REG_INIT_VOLUME:    cfg_init_vol   = values[i][4:0];
                REG_VOLUME_LIMIT:   cfg_vol_limit  = values[i][4:0];
                REG_SPLASH_LENGTH:  cfg_splash_len = values[i];
                REG_PROGRESS_LIMIT: cfg_prog_limit = values[i][6:0];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_event(input logic [1:0] cmd, input logic [2:0] key,
                              input logic [2:0] kind);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, kind, key};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_event(cmd, key, kind);
    endtask

    task automatic send_random_event();
        int pick;
        logic [1:0] cmd;
        logic [2:0] key;
        logic [2:0] kind;
        pick = $urandom_range(99);
        cmd  = CMD_KEY;
        key  = 3'($urandom_range(5));
        kind = KIND_SHORT;
        if (pick < 30) begin
            cmd  = CMD_TICK;
            key  = 3'($urandom_range(7));
            kind = 3'($urandom_range(7));
        end else if (pick < 78) begin
        end else if (pick < 84) begin
            key  = KEY_OK;
            kind = KIND_LONG;
        end else if (pick < 87) begin
            cmd = CMD_START;
        end else begin
            if (pick >= 97) cmd = CMD_UNUSED;
            key  = 3'($urandom_range(7));
            kind = 3'($urandom_range(7));
            // keep the exit key for the final test
            if (cmd == CMD_KEY && kind == KIND_LONG && key == KEY_BACK) kind = KIND_REPEAT;
        end
        send_event(cmd, key, kind);
    endtask

    task automatic test_splash_exit();
        configure(5'd20, 5'd30, 8'd3, 7'd100);
        send_event(CMD_TICK, KEY_UP, KIND_PRESS);
        send_event(CMD_TICK, KEY_UP, KIND_PRESS);
        send_event(CMD_KEY, KEY_UP, KIND_PRESS);
    endtask

    task automatic test_player_keys();
        send_event(CMD_KEY, KEY_UP, KIND_SHORT);
        send_event(CMD_KEY, KEY_DOWN, KIND_SHORT);
        send_event(CMD_KEY, KEY_RIGHT, KIND_SHORT);
        send_event(CMD_KEY, KEY_LEFT, KIND_SHORT);
        send_event(CMD_KEY, KEY_OK, KIND_SHORT);
        send_event(CMD_TICK, KEY_DOWN, KIND_RELEASE);
        send_event(CMD_KEY, KEY_OK, KIND_SHORT);
        send_event(CMD_KEY, KEY_BACK, KIND_SHORT);
        send_event(CMD_KEY, KEY_OK, KIND_LONG);
        send_event(CMD_KEY, KEY_UP, KIND_SHORT);
        send_event(CMD_KEY, KEY_BACK, KIND_SHORT);
        send_event(CMD_START, KEY_BACK, KIND_LONG);
        send_event(CMD_UNUSED, KEY_OK, KIND_SHORT);
        send_event(CMD_KEY, KEY_UNUSED, KIND_SHORT);
    endtask

    task automatic test_volume_limits();
        configure(5'd30, 5'd31, 8'd4, 7'd100);
        send_event(CMD_START, KEY_UP, KIND_PRESS);
        send_event(CMD_KEY, KEY_UP, KIND_SHORT);
        // volume now sits above the limit
        configure(5'd0, 5'd10, 8'd4, 7'd100);
        send_event(CMD_KEY, KEY_UP, KIND_SHORT);
        send_event(CMD_KEY, KEY_DOWN, KIND_SHORT);
        send_event(CMD_START, KEY_UP, KIND_PRESS);
        send_event(CMD_KEY, KEY_DOWN, KIND_SHORT);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_random_event();
    endtask

    task automatic test_backpressure();
        configure(5'd20, 5'd30, 8'd4, 7'd127);
        send_event(CMD_START, KEY_UP, KIND_PRESS);
        if (scr == SCR_HELP) send_event(CMD_KEY, KEY_OK, KIND_SHORT);
        stall_request = 400;
        repeat (140) send_event(CMD_TICK, KEY_UP, KIND_PRESS);
    endtask

    task automatic test_halt();
        send_event(CMD_KEY, KEY_BACK, KIND_LONG);
        send_event(CMD_TICK, KEY_UP, KIND_PRESS);
        send_event(CMD_START, KEY_UP, KIND_PRESS);
        send_event(CMD_KEY, KEY_OK, KIND_SHORT);
    endtask

    initial begin
        reset_predictor();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_splash_exit();
        test_player_keys();
        test_volume_limits();
        configure(5'd0, 5'd31, 8'd0, 7'd1);
        test_random_traffic(110, 33, 80);
        configure(5'd30, 5'd0, 8'd255, 7'd127);
        test_random_traffic(110, 80, 33);
        configure(5'($urandom_range(30)), 5'($urandom_range(31)), 8'($urandom_range(255)),
                  7'($urandom_range(127, 1)));
        test_random_traffic(110, 0, 0);
        test_backpressure();
        test_halt();
        wait_idle(20);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
